### hdl/des_block_cipher_defines.svh
// Assertion macros for the DES block
`ifndef DES_BLOCK_CIPHER_DEFINES_SVH
`define DES_BLOCK_CIPHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DES_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DES_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/des_pkg.sv
package des_pkg;

  typedef logic [63:0] blk_t;
  typedef logic [47:0] subkey_t;

  localparam int unsigned TAB_IP [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam int unsigned TAB_FP [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam int unsigned TAB_E [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam int unsigned TAB_P [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam int unsigned TAB_PC1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam int unsigned TAB_PC2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam int unsigned TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] TAB_S [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,5,6,3,11}};

  function automatic blk_t perm_ip(input blk_t v);
    blk_t r;
    for (int k = 0; k < 64; k++) r[63-k] = v[64-TAB_IP[k]];
    return r;
  endfunction

  function automatic blk_t perm_fp(input blk_t v);
    blk_t r;
    for (int k = 0; k < 64; k++) r[63-k] = v[64-TAB_FP[k]];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0] b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
    x = x ^ k;
    for (int j = 0; j < 8; j++) begin
      b = x[47-6*j -: 6];
      s[31-4*j -: 4] = TAB_S[j][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
    return p;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input int unsigned s);
    return (s == 1) ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
  endfunction

endpackage

### hdl/des_keysched.sv
// Registered key schedule: subkeys for the configured key.
module des_keysched (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  des_pkg::blk_t          key,
  output des_pkg::subkey_t       subkeys [16]
);
  import des_pkg::*;

  logic [27:0] c [17];
  logic [27:0] d [17];
  subkey_t     sk_next [16];
  logic [55:0] cd0;
  logic [55:0] cd;

  always_comb begin
    for (int k = 0; k < 56; k++) cd0[55-k] = key[64-TAB_PC1[k]];
    c[0] = cd0[55:28];
    d[0] = cd0[27:0];
    for (int i = 0; i < 16; i++) begin
      c[i+1] = rot28(c[i], TAB_ROT[i]);
      d[i+1] = rot28(d[i], TAB_ROT[i]);
      cd = {c[i+1], d[i+1]};
      for (int k = 0; k < 48; k++) sk_next[i][47-k] = cd[56-TAB_PC2[k]];
    end
  end

  // all-zero key gives all-zero subkeys
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (rst) subkeys[i] <= '0;
      else if (wr) subkeys[i] <= sk_next[i];
    end
  end
endmodule

### hdl/des_round.sv
// One Feistel round stage with stall-aware valid.
module des_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_vld,
  input  des_pkg::blk_t    in_lr,
  input  logic             in_enc,
  input  des_pkg::subkey_t key_enc,
  input  des_pkg::subkey_t key_dec,
  output logic             out_vld,
  output des_pkg::blk_t    out_lr,
  output logic             out_enc
);
  import des_pkg::*;

  logic [31:0] t;

  assign t = in_lr[63:32] ^ feistel(in_lr[31:0], in_enc ? key_enc : key_dec);

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (adv) out_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lr  <= {in_lr[31:0], t};
      out_enc <= in_enc;
    end
  end
endmodule

### hdl/des_block_cipher.sv
// Channel   | Signals                                  | Dir
// input     | valid_in, stall_in, block_in, encrypt_mode| in (stall out)
// output    | valid, stall, block_out                  | out (stall in)
// config    | cfg_valid, cfg_ready, des_key            | in (ready out)
// One block enters per cycle unless stalled (IP stage, one stage per
// round, final permutation stage into the output register).
// The whole pipeline holds while the output is stalled and full.
// Synchronous reset empties the pipeline and loads the all-zero key schedule.
`include "des_block_cipher_defines.svh"
module des_block_cipher #(
  parameter int ROUNDS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  output logic          stall_in,
  input  des_pkg::blk_t block_in,
  input  logic          encrypt_mode,
  output logic          valid,
  input  logic          stall,
  output des_pkg::blk_t block_out,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  des_pkg::blk_t des_key
);
  import des_pkg::*;

  subkey_t subkeys [16];
  logic    adv;
  logic    vld [ROUNDS+1];
  blk_t    lr  [ROUNDS+1];
  logic    enc [ROUNDS+1];

  // advance whenever output slot is free or being drained
  assign adv       = !valid || !stall;
  assign stall_in  = !adv;
  assign cfg_ready = 1'b1;

  des_keysched u_ks (
    .clk(clk), .rst(rst), .wr(cfg_valid), .key(des_key), .subkeys(subkeys)
  );

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= valid_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lr[0]  <= perm_ip(block_in);
      enc[0] <= encrypt_mode;
    end
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_rnd
    des_round u_rnd (
      .clk(clk), .rst(rst), .adv(adv),
      .in_vld(vld[i]), .in_lr(lr[i]), .in_enc(enc[i]),
      .key_enc(subkeys[i]), .key_dec(subkeys[ROUNDS-1-i]),
      .out_vld(vld[i+1]), .out_lr(lr[i+1]), .out_enc(enc[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (adv) valid <= vld[ROUNDS];
  end

  // swap halves before the final permutation
  always_ff @(posedge clk) begin
    if (adv) block_out <= perm_fp({lr[ROUNDS][31:0], lr[ROUNDS][63:32]});
  end

  `DES_ASSERT_IMPL(a_stall_back, clk, rst, valid && stall, stall_in)
  `DES_ASSERT_NEXT(a_hold_out, clk, rst, valid && stall, valid && $stable(block_out))
  `DES_ASSERT_NEXT(a_first_stage, clk, rst, valid_in && !stall_in, vld[0])
endmodule
